>>> hdl/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the stack pattern censor.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int PATTERN_MAX_DEF = 16;

    localparam int TEXT_W     = 8;
    localparam int POS_W      = 10;
    localparam int KEPT_W     = 11;
    localparam int MASK_W     = 16;
    localparam int LEN_W      = 5;
    localparam int REG_W      = 64;
    localparam int APB_AW     = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [0:0] {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_PAT_LO  = 2'd0,
        REG_PAT_HI  = 2'd1,
        REG_PAT_LEN = 2'd2
    } t_reg_idx;

    typedef enum logic [0:0] {
        BK_RUN  = 1'b0,
        BK_WAIT = 1'b1
    } t_back_state;

    typedef enum logic [0:0] {
        WAIT_READ = 1'b0,
        WAIT_VEC  = 1'b1
    } t_wait_kind;

    typedef struct packed {
        logic [2*REG_W-1:0] pattern;
        logic [LEN_W-1:0]   length;
    } t_cfg;

    typedef struct packed {
        t_cmd              cmd;
        logic [TEXT_W-1:0] text_byte;
        logic [POS_W-1:0]  read_position;
        logic [MASK_W-1:0] match_mask;
        logic [MASK_W-1:0] last_sel;
        logic [LEN_W-1:0]  used_len;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic [KEPT_W-1:0] kept_length;
        logic              deleted;
        logic [TEXT_W-1:0] read_byte;
        logic              refused;
    } t_result;

endpackage

>>> hdl/spc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface spc_in_if import spc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [TEXT_W-1:0] text_byte;
    logic [POS_W-1:0]  read_position;

    modport source (output valid, cmd, text_byte, read_position, input ready);
    modport sink   (input valid, cmd, text_byte, read_position, output ready);
endinterface

interface spc_out_if import spc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KEPT_W-1:0] kept_length;
    logic              deleted;
    logic [TEXT_W-1:0] read_byte;
    logic              refused;

    modport source (output valid, kept_length, deleted, read_byte, refused, input ready);
    modport sink   (input valid, kept_length, deleted, read_byte, refused, output ready);
endinterface

>>> hdl/spc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_cfg
// APB register file holding the pattern bytes and the pattern length.
// ----------------------------------------------------------------------------
module spc_cfg import spc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [REG_W-1:0] r_pat_lo;
    logic [REG_W-1:0] r_pat_hi;
    logic [LEN_W-1:0] r_pat_len;
    t_reg_idx         w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:3]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PAT_LO:  r_pat_lo  <= pwdata;
                REG_PAT_HI:  r_pat_hi  <= pwdata;
                REG_PAT_LEN: r_pat_len <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAT_LO:  prdata = r_pat_lo;
            REG_PAT_HI:  prdata = r_pat_hi;
            REG_PAT_LEN: prdata = REG_W'(r_pat_len);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.pattern = {r_pat_hi, r_pat_lo};
    assign o_cfg.length  = r_pat_len;

endmodule

>>> hdl/spc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_front
// Accept command words and classify them: per-byte pattern match mask,
// used pattern length and the one-hot of the last pattern position.
// ----------------------------------------------------------------------------
module spc_front import spc_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    spc_in_if.sink   i_in,
    input  t_cfg     i_cfg,
    input  logic     i_q_full,
    output t_q_head  o_push
);

    logic [LEN_W-1:0]  w_used;
    logic [MASK_W-1:0] w_mask;
    logic [MASK_W-1:0] w_last;

    assign w_used = (i_cfg.length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : i_cfg.length;

    always_comb begin
        for (int j = 0; j < MASK_W; j++) begin
            w_mask[j] = (j < PATTERN_MAX) && (LEN_W'(j) < w_used)
                        && (i_cfg.pattern[8*j +: 8] == i_in.text_byte);
            w_last[j] = (j < PATTERN_MAX) && (LEN_W'(j + 1) == w_used);
        end
    end

    assign i_in.ready = ~i_q_full;

    assign o_push.valid              = i_in.valid & ~i_q_full;
    assign o_push.item.cmd           = t_cmd'(i_in.cmd);
    assign o_push.item.text_byte     = i_in.text_byte;
    assign o_push.item.read_position = i_in.read_position;
    assign o_push.item.match_mask    = w_mask;
    assign o_push.item.last_sel      = w_last;
    assign o_push.item.used_len      = w_used;

endmodule

>>> hdl/spc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module spc_queue import spc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_head i_push,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_slot [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [LW-1:0]  r_level;
    logic           w_wr;
    logic           w_rd;

    assign o_full      = (r_level == LW'(QUEUE_DEPTH));
    assign o_head.valid = (r_level != '0);
    assign o_head.item  = r_slot[r_rd_ptr];
    assign w_wr = i_push.valid & ~o_full;
    assign w_rd = i_pop & o_head.valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_level <= r_level + LW'(1);
                2'b01:   r_level <= r_level - LW'(1);
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

>>> hdl/spc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_back
// Execute pushes and reads against the stack memory, track the top match
// vector and hold the result word in an output register.
// ----------------------------------------------------------------------------
module spc_back import spc_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_q_head  i_head,
    output logic     o_pop,
    spc_out_if.source o_out
);

    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int DW   = TEXT_W + PATTERN_MAX;

    logic [DW-1:0]          mem [STACK_DEPTH];
    logic [DW-1:0]          r_rdata;
    t_back_state            r_state;
    t_back_state            n_state;
    t_wait_kind             r_kind;
    t_wait_kind             n_kind;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [PATTERN_MAX-1:0] r_top;
    logic [PATTERN_MAX-1:0] n_top;
    logic                   r_out_valid;
    t_result                r_res;
    t_result                n_res;
    logic                   w_emit;
    logic                   w_we;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic                   w_out_free;
    logic                   w_go;
    logic [CMPW-1:0]        w_pos_ext;
    logic                   w_rd_ok;
    logic                   w_full;
    logic [PATTERN_MAX-1:0] w_vec;
    logic                   w_hit;
    logic [CW-1:0]          w_new_count;
    logic [CW-1:0]          w_new_m1;

    assign w_out_free = ~r_out_valid | o_out.ready;
    assign w_go       = i_head.valid & w_out_free;
    assign w_pos_ext  = CMPW'(i_head.item.read_position);
    assign w_rd_ok    = w_pos_ext < CMPW'(r_count);
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_vec      = ((r_top << 1) | PATTERN_MAX'(1'b1))
                        & i_head.item.match_mask[PATTERN_MAX-1:0];
    assign w_hit      = (|(w_vec & i_head.item.last_sel[PATTERN_MAX-1:0]))
                        && ((r_count + CW'(1)) >= CW'(i_head.item.used_len));
    assign w_new_count = r_count + CW'(1) - CW'(i_head.item.used_len);
    assign w_new_m1    = w_new_count - CW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_RUN: begin
                if (w_go) begin
                    if (i_head.item.cmd == CMD_READ) begin
                        if (w_rd_ok) begin
                            n_state = BK_WAIT;
                        end
                    end else if (!w_full && w_hit && (w_new_count != '0)) begin
                        n_state = BK_WAIT;
                    end
                end
            end
            BK_WAIT: begin
                if (r_kind == WAIT_VEC || w_out_free) begin
                    n_state = BK_RUN;
                end
            end
            default: n_state = BK_RUN;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        w_emit  = 1'b0;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_raddr = r_count[AW-1:0];
        n_count = r_count;
        n_top   = r_top;
        n_kind  = r_kind;
        n_res   = r_res;
        case (r_state)
            BK_RUN: begin
                if (w_go) begin
                    o_pop = 1'b1;
                    n_res = '{kept_length: KEPT_W'(r_count), deleted: 1'b0,
                              read_byte: '0, refused: 1'b0};
                    if (i_head.item.cmd == CMD_READ) begin
                        if (w_rd_ok) begin
                            w_re    = 1'b1;
                            w_raddr = w_pos_ext[AW-1:0];
                            n_kind  = WAIT_READ;
                        end else begin
                            w_emit        = 1'b1;
                            n_res.refused = 1'b1;
                        end
                    end else if (w_full) begin
                        w_emit        = 1'b1;
                        n_res.refused = 1'b1;
                    end else if (w_hit) begin
                        w_emit            = 1'b1;
                        n_count           = w_new_count;
                        n_res.kept_length = KEPT_W'(w_new_count);
                        n_res.deleted     = 1'b1;
                        if (w_new_count == '0) begin
                            n_top = '0;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = w_new_m1[AW-1:0];
                            n_kind  = WAIT_VEC;
                        end
                    end else begin
                        w_emit            = 1'b1;
                        w_we              = 1'b1;
                        n_count           = r_count + CW'(1);
                        n_top             = w_vec;
                        n_res.kept_length = KEPT_W'(r_count + CW'(1));
                    end
                end
            end
            BK_WAIT: begin
                if (r_kind == WAIT_VEC) begin
                    n_top = r_rdata[PATTERN_MAX-1:0];
                end else if (w_out_free) begin
                    w_emit = 1'b1;
                    n_res  = '{kept_length: KEPT_W'(r_count), deleted: 1'b0,
                               read_byte: r_rdata[DW-1 -: TEXT_W], refused: 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_count[AW-1:0]] <= {i_head.item.text_byte, w_vec};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_kind      <= WAIT_READ;
            r_count     <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_count     <= n_count;
            r_top       <= n_top;
            r_out_valid <= w_emit | (r_out_valid & ~o_out.ready);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kept_length = r_res.kept_length;
    assign o_out.deleted     = r_res.deleted;
    assign o_out.read_byte   = r_res.read_byte;
    assign o_out.refused     = r_res.refused;

endmodule

>>> hdl/stack_pattern_censor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_pattern_censor_core
// Streaming censor: bytes go onto a stack, a completed pattern is removed.
//
// i_in takes one command word: cmd 0 pushes text_byte, cmd 1 reads the kept
// byte at read_position. o_out returns exactly one result word per command:
// kept length, deleted flag, read byte and refused flag.
// The APB port writes the pattern bytes and the pattern length (8-byte
// register stride); program it only while no word is in flight.
// A push result passes the queue slot and the output register; a read also
// passes the memory read register. Throughput: one push per cycle while the
// receiver takes results; a read, or a deletion that leaves bytes on the
// stack, holds the execute stage in its wait state (single registered read
// port; the vector below a deleted run is read back before the next word).
// A two-word queue and the output register decouple the sides: input is
// still accepted while a result waits on a stalled receiver, until the
// queue fills. Reset empties the stack and clears the pattern registers;
// no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module stack_pattern_censor_core import spc_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spc_in_if.sink            i_in,
    spc_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready
);

    t_cfg    w_cfg;
    t_q_head w_push;
    t_q_head w_head;
    logic    w_q_full;
    logic    w_pop;

    spc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    spc_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_in     (i_in),
        .i_cfg    (w_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push)
    );

    spc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    spc_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

>>> dv/spc_censor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_censor_checker
// Watches the command, result and APB channels of the stack pattern censor.
// Keeps its own stack, match vectors and pattern registers, works out the
// result of every accepted command word and compares each result word, field
// by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module spc_censor_checker import spc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spc_in_if                 i_in,
    spc_out_if                i_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [REG_W-1:0]  i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_level,
    output int                o_checked,
    output int                o_deletions,
    output int                o_refusals
);

    localparam int DEPTH      = STACK_DEPTH_DEF;
    localparam int PMAX       = PATTERN_MAX_DEF;

    logic [REG_W-1:0]  pat_lo;
    logic [REG_W-1:0]  pat_hi;
    logic [LEN_W-1:0]  pat_len;
    logic [TEXT_W-1:0] text_store [DEPTH];
    logic [MASK_W-1:0] vec_store [DEPTH];
    int                stack_fill;
    logic [MASK_W-1:0] top_vec;
    t_result           expected_words [$];
    int                fails;
    int                checked;
    int                deletions;
    int                refusals;

    function automatic t_result censor_word(t_cmd cmd, logic [TEXT_W-1:0] ch,
                                            logic [POS_W-1:0] pos);
        t_result            res;
        int                 n;
        logic [MASK_W-1:0]  hits;
        logic [MASK_W-1:0]  d;
        logic [2*REG_W-1:0] pat;
        res = '0;
        pat = {pat_hi, pat_lo};
        n = (int'(pat_len) > PMAX) ? PMAX : int'(pat_len);
        if (cmd == CMD_READ) begin
            if (int'(pos) < stack_fill) begin
                res.read_byte = text_store[pos];
            end else begin
                res.refused = 1'b1;
            end
        end else if (stack_fill >= DEPTH) begin
            res.refused = 1'b1;
        end else begin
            hits = '0;
            for (int j = 0; j < n; j++) begin
                if (pat[8*j +: 8] == ch) begin
                    hits[j] = 1'b1;
                end
            end
            d = {top_vec[MASK_W-2:0], 1'b1} & hits;
            if (n > 0 && d[n-1] && stack_fill + 1 >= n) begin
                stack_fill = stack_fill + 1 - n;
                top_vec = (stack_fill != 0) ? vec_store[stack_fill-1] : '0;
                res.deleted = 1'b1;
            end else begin
                text_store[stack_fill] = ch;
                vec_store[stack_fill] = d;
                stack_fill++;
                top_vec = d;
            end
        end
        res.kept_length = KEPT_W'(stack_fill);
        return res;
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            pat_lo = '0;
            pat_hi = '0;
            pat_len = '0;
            stack_fill = 0;
            top_vec = '0;
            expected_words.delete();
            fails = 0;
            checked = 0;
            deletions = 0;
            refusals = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_AW-1:3]))
                    REG_PAT_LO:  pat_lo = i_pwdata;
                    REG_PAT_HI:  pat_hi = i_pwdata;
                    REG_PAT_LEN: pat_len = i_pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            // retire the result word before queueing the new command word
            if (i_out.valid && i_out.ready) begin
                checked++;
                if (expected_words.size() == 0) begin
                    fails++;
                    $display("%0t: result word with nothing expected, kept_length %0d",
                             $time, i_out.kept_length);
                end else begin
                    want = expected_words.pop_front();
                    check_field("kept_length", want.kept_length, i_out.kept_length);
                    check_field("deleted", want.deleted, i_out.deleted);
                    check_field("read_byte", want.read_byte, i_out.read_byte);
                    check_field("refused", want.refused, i_out.refused);
                end
            end
            if (i_in.valid && i_in.ready) begin
                want = censor_word(t_cmd'(i_in.cmd), i_in.text_byte, i_in.read_position);
                deletions += want.deleted;
                refusals += want.refused;
                expected_words.insert(expected_words.size(), want);
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_words.size();
        o_level <= stack_fill;
        o_checked <= checked;
        o_deletions <= deletions;
        o_refusals <= refusals;
    end

endmodule

>>> dv/stack_pattern_censor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_pattern_censor_core_tb
// Drives command words and pattern settings into the stack pattern censor and
// gives the verdict from the checker beside it. A short directed part covers
// cascading deletion, disabled and saturated pattern lengths and refused
// reads; random phases mix pattern runs, broken runs, noise and reads under
// random stalls; a last phase fills the stack and pushes into it while full.
// ----------------------------------------------------------------------------
module stack_pattern_censor_core_tb;
    import spc_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int LONG_HOLD   = 120;
    localparam int TAIL_CYCLES = 12;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 20;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [REG_W-1:0]   pwdata;
    logic [REG_W-1:0]   prdata;
    logic               pready;

    int                 fail_count;
    int                 pending;
    int                 level;
    int                 checked;
    int                 deletions;
    int                 refusals;
    int                 idle_pct = 0;
    int                 long_hold_asks = 0;
    int                 long_hold_done = 0;
    int                 words_sent = 0;
    logic [2*REG_W-1:0] cur_pat;
    int                 cur_len;

    spc_in_if  in_ch ();
    spc_out_if out_ch ();

    stack_pattern_censor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spc_censor_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_level      (level),
        .o_checked    (checked),
        .o_deletions  (deletions),
        .o_refusals   (refusals)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for result words");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls plus the long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_asks != long_hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done++;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [REG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 3'b000});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pattern(logic [2*REG_W-1:0] pat, logic [LEN_W-1:0] len);
        logic [REG_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        reg_write(REG_PAT_LO, pat[REG_W-1:0]);
        reg_write(REG_PAT_HI, pat[2*REG_W-1:REG_W]);
        reg_write(REG_PAT_LEN, len_word);
        cur_pat = pat;
        cur_len = (int'(len) > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(len);
    endtask

    task automatic send_word(t_cmd cmd, logic [TEXT_W-1:0] ch, logic [POS_W-1:0] pos);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.text_byte <= ch;
        in_ch.read_position <= pos;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [POS_W-1:0] read_spot();
        int top_pos;
        if ($urandom_range(0, 7) == 0) begin
            return POS_W'($urandom);
        end
        top_pos = (level + 2 > DEPTH - 1) ? DEPTH - 1 : level + 2;
        return POS_W'($urandom_range(0, top_pos));
    endfunction

    task automatic pick_pattern(int phase);
        logic [2*REG_W-1:0] pat;
        logic [LEN_W-1:0]   len;
        logic [TEXT_W-1:0]  sym_a;
        logic [TEXT_W-1:0]  sym_b;
        int                 roll;
        sym_a = TEXT_W'($urandom);
        sym_b = TEXT_W'($urandom);
        roll = $urandom_range(0, 2);
        for (int j = 0; j < PATTERN_MAX_DEF; j++) begin
            if (roll == 0) begin
                pat[8*j +: 8] = TEXT_W'($urandom);
            end else begin
                pat[8*j +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
            end
        end
        case ($urandom_range(0, 9))
            0: len = '0;
            1: len = LEN_W'($urandom_range(17, 31));
            2: len = LEN_W'($urandom_range(7, 16));
            default: len = LEN_W'($urandom_range(1, 5));
        endcase
        if (phase == 3) begin
            pat = '0;
            len = LEN_W'(4);
        end
        if (phase == 5) begin
            len = LEN_W'(PATTERN_MAX_DEF);
        end
        set_pattern(pat, len);
    endtask

    task automatic random_phase(int n_words);
        int done;
        int roll;
        int run;
        done = 0;
        while (done < n_words) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                send_word(CMD_READ, TEXT_W'($urandom), read_spot());
                done++;
            end else if (roll < 40 || cur_len == 0) begin
                send_word(CMD_PUSH, TEXT_W'($urandom), POS_W'($urandom));
                done++;
            end else begin
                // whole pattern or a broken prefix of it
                run = (roll < 75) ? cur_len : $urandom_range(1, cur_len);
                for (int j = 0; j < run; j++) begin
                    send_word(CMD_PUSH, cur_pat[8*j +: 8], POS_W'($urandom));
                end
                done += run;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_PUSH;
        in_ch.text_byte = '0;
        in_ch.read_position = '0;
        cur_pat = '0;
        cur_len = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // deletion disabled after reset, field extremes, refused read
        send_word(CMD_PUSH, 8'h00, '0);
        send_word(CMD_PUSH, 8'hFF, '1);
        send_word(CMD_READ, 8'hFF, '0);
        send_word(CMD_READ, 8'h00, '1);
        drain();

        // cascade: "abab" then "c" drops the inner run, the next "c" the outer
        set_pattern(128'h636261, LEN_W'(3));
        send_word(CMD_PUSH, 8'h61, '0);
        send_word(CMD_PUSH, 8'h62, '0);
        send_word(CMD_PUSH, 8'h61, '0);
        send_word(CMD_PUSH, 8'h62, '0);
        send_word(CMD_PUSH, 8'h63, '0);
        send_word(CMD_PUSH, 8'h63, '0);
        drain();

        // length above the maximum saturates; stored vectors stay as they were
        set_pattern('1, LEN_W'(31));
        repeat (PATTERN_MAX_DEF) send_word(CMD_PUSH, 8'hFF, POS_W'($urandom));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            idle_pct = (p == 0) ? 0 : $urandom_range(10, 45);
            pick_pattern(p);
            if (p == 2 || p == 6) begin
                long_hold_asks++;
            end
            random_phase(PHASE_WORDS);
            drain();
        end

        // no idling from here: fill the stack, then push and read while full
        idle_pct = 0;
        set_pattern({$urandom, $urandom, $urandom, $urandom}, '0);
        while (level < DEPTH) begin
            if ($urandom_range(0, 15) == 0) begin
                send_word(CMD_READ, TEXT_W'($urandom), read_spot());
            end else begin
                send_word(CMD_PUSH, TEXT_W'($urandom), POS_W'($urandom));
            end
        end
        drain();
        set_pattern(128'h5A, LEN_W'(1));
        send_word(CMD_PUSH, 8'h5A, '0);
        send_word(CMD_READ, 8'h00, '1);
        send_word(CMD_READ, 8'hFF, '0);
        repeat (30) begin
            if ($urandom_range(0, 1) == 0) begin
                send_word(CMD_PUSH, $urandom_range(0, 1) ? 8'h5A : TEXT_W'($urandom),
                          POS_W'($urandom));
            end else begin
                send_word(CMD_READ, TEXT_W'($urandom), POS_W'($urandom));
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d command words, checked %0d result words", words_sent, checked);
        $display("Saw %0d deletions and %0d refusals; stack ended at %0d bytes",
                 deletions, refusals, level);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
